>>> hw/rtl/fsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsb_pkg;

   localparam int MAP_DEPTH_DEFAULT = 1024;
   // Offsets never reach past this, whatever the map depth
   localparam int LEN_LIMIT         = 1024;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_STRATEGY      = 2'd0;
   localparam logic [1:0] REG_REGION_BASE   = 2'd1;
   localparam logic [1:0] REG_REGION_LENGTH = 2'd2;

   localparam logic OP_SET    = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [10:0] REGION_LENGTH_RESET = 11'd1024;

   typedef enum logic [1:0] {
      STRAT_FIRST = 2'd0,
      STRAT_NEXT  = 2'd1,
      STRAT_BEST  = 2'd2,
      STRAT_WORST = 2'd3
   } strategy_type;

   typedef struct packed {
      logic        operation;
      logic [9:0]  entry_index;
      logic        entry_used;
      logic [10:0] request_size;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [16:0] block_address;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/fsb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fsb_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/free_block_search.sv
// A set item, or a search that fails on its size, gives its result beat straight from idle with no scan.
// Any other search scans the effective region length, and next fit may wrap round for a second pass.
// One scan sequencer reads the map RAM an entry a cycle.
// Requests: one item at a time, taken only after the previous result beat has left.
// Reset: synchronous; then the map RAM is cleared an entry a cycle over min(MAP_DEPTH, 1024)
// entries with req_ready low; register writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module free_block_search #(
   parameter int MAP_DEPTH = fsb_pkg::MAP_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire fsb_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output fsb_pkg::rsp_type                      rsp_data,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [fsb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [fsb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [fsb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   localparam int MEM_DEPTH = (MAP_DEPTH < fsb_pkg::LEN_LIMIT) ? MAP_DEPTH
                                                               : fsb_pkg::LEN_LIMIT;
   localparam int AW = $clog2(MEM_DEPTH);
   localparam logic [10:0]   LEN_CAP  = 11'(MEM_DEPTH);
   localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [10:0]            iss_ff, iss_in;
   logic                   pend_ff, pend_in;
   logic [9:0]             pend_off_ff, pend_off_in;
   logic                   pass2_ff, pass2_in;
   logic [10:0]            run_ff, run_in;
   logic [9:0]             run_start_ff, run_start_in;
   logic                   have_ff, have_in;
   logic [10:0]            pick_ff, pick_in;
   logic [9:0]             at_ff, at_in;
   logic [10:0]            size_ff, size_in;
   logic [9:0]             resume_off_ff, resume_off_in;
   logic                   resume_vld_ff, resume_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fsb_pkg::rsp_type       rsp_ff, rsp_in;

   fsb_pkg::strategy_type  strategy_ff;
   logic [15:0]            region_base_ff;
   logic [10:0]            region_length_ff;

   logic                   ram_we;
   logic [AW-1:0]          ram_wr_addr;
   logic                   ram_wr_data;
   logic                   rd_bit;

   logic [10:0]            eff_len;
   logic                   req_accept;
   logic                   csr_write;
   logic                   hole_mode;
   logic                   last_beat;
   logic                   free_beat;
   logic [10:0]            run_inc;
   logic [9:0]             start_n;
   logic                   run_hit;
   logic                   hole_end;
   logic [10:0]            hole_len;
   logic [9:0]             hole_st;
   logic                   better;
   logic                   have_n;
   logic [9:0]             at_n;
   logic                   pass_end;
   logic                   issue;
   logic [10:0]            block_end;

   fsb_ram #(
      .WIDTH (1),
      .DEPTH (MEM_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (iss_ff[AW-1:0]),
      .rd_data (rd_bit)
   );

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff      <= fsb_pkg::STRAT_FIRST;
         region_base_ff   <= '0;
         region_length_ff <= fsb_pkg::REGION_LENGTH_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            fsb_pkg::REG_STRATEGY:      strategy_ff <= fsb_pkg::strategy_type'(pwdata[1:0]);
            fsb_pkg::REG_REGION_BASE:   region_base_ff <= pwdata[15:0];
            fsb_pkg::REG_REGION_LENGTH: region_length_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         fsb_pkg::REG_STRATEGY:      prdata = 32'(strategy_ff);
         fsb_pkg::REG_REGION_BASE:   prdata = 32'(region_base_ff);
         fsb_pkg::REG_REGION_LENGTH: prdata = 32'(region_length_ff);
         default:                    prdata = '0;
      endcase
   end

   assign eff_len = (region_length_ff > LEN_CAP) ? LEN_CAP : region_length_ff;

   // Handshakes
   assign req_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Scan datapath: the read data belongs to offset pend_off_ff
   assign hole_mode = (strategy_ff == fsb_pkg::STRAT_BEST) ||
                      (strategy_ff == fsb_pkg::STRAT_WORST);
   assign last_beat = pend_ff && ({1'b0, pend_off_ff} == (eff_len - 11'd1));
   assign free_beat = pend_ff && !rd_bit;
   assign run_inc   = run_ff + 11'd1;
   assign start_n   = (run_ff == 11'd0) ? pend_off_ff : run_start_ff;
   assign run_hit   = !hole_mode && free_beat && (run_inc == size_ff);

   // A hole closes on a used entry or at the end of the region
   assign hole_end = pend_ff && (rd_bit || last_beat);
   assign hole_len = rd_bit ? run_ff : run_inc;
   assign hole_st  = rd_bit ? run_start_ff : start_n;
   assign better   = hole_end && (hole_len >= size_ff) &&
                     (!have_ff ||
                      ((strategy_ff == fsb_pkg::STRAT_WORST) ? (hole_len > pick_ff)
                                                              : (hole_len < pick_ff)));
   assign have_n   = have_ff || better;
   assign at_n     = better ? hole_st : at_ff;

   assign pass_end  = last_beat || (!pend_ff && (iss_ff >= eff_len));
   assign issue     = (state_ff == ST_SCAN) && (iss_ff < eff_len) && !run_hit && !pass_end;
   assign block_end = {1'b0, start_n} + size_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      iss_in        = iss_ff;
      pend_in       = issue;
      pend_off_in   = iss_ff[9:0];
      pass2_in      = pass2_ff;
      run_in        = run_ff;
      run_start_in  = run_start_ff;
      have_in       = have_ff;
      pick_in       = pick_ff;
      at_in         = at_ff;
      size_in       = size_ff;
      resume_off_in = resume_off_ff;
      resume_vld_in = resume_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = req_data.entry_index[AW-1:0];
      ram_wr_data   = req_data.entry_used;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = 1'b0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.operation == fsb_pkg::OP_SET) begin
                  ram_we       = ({1'b0, req_data.entry_index} < eff_len);
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end else if ((req_data.request_size == 11'd0) ||
                            (req_data.request_size > eff_len)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (strategy_ff == fsb_pkg::STRAT_NEXT) begin
                     resume_off_in = '0;
                     resume_vld_in = 1'b0;
                  end
               end else begin
                  state_in = ST_SCAN;
                  size_in  = req_data.request_size;
                  run_in   = '0;
                  have_in  = 1'b0;
                  pick_in  = '0;
                  at_in    = '0;
                  pass2_in = 1'b0;
                  iss_in   = ((strategy_ff == fsb_pkg::STRAT_NEXT) && resume_vld_ff)
                             ? {1'b0, resume_off_ff} : 11'd0;
               end
            end
         end

         ST_SCAN: begin
            if (issue) begin
               iss_in = iss_ff + 11'd1;
            end
            if (pend_ff) begin
               if (rd_bit) begin
                  run_in = '0;
               end else begin
                  run_in       = run_inc;
                  run_start_in = start_n;
               end
            end
            if (better) begin
               have_in = 1'b1;
               pick_in = hole_len;
               at_in   = hole_st;
            end

            if (run_hit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.found = 1'b1;
               rsp_in.block_address = {1'b0, region_base_ff} + 17'(start_n);
               if (strategy_ff == fsb_pkg::STRAT_NEXT) begin
                  resume_off_in = (block_end >= eff_len) ? 10'd0 : block_end[9:0];
                  resume_vld_in = 1'b1;
               end
            end else if (pass_end) begin
               if (hole_mode) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in.found = have_n;
                  rsp_in.block_address = have_n ? ({1'b0, region_base_ff} + 17'(at_n))
                                                : 17'd0;
               end else if ((strategy_ff == fsb_pkg::STRAT_NEXT) && !pass2_ff) begin
                  // wrap round and scan again from the region start
                  pass2_in = 1'b1;
                  iss_in   = '0;
                  run_in   = '0;
               end else begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (strategy_ff == fsb_pkg::STRAT_NEXT) begin
                     resume_off_in = '0;
                     resume_vld_in = 1'b0;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         pend_ff       <= 1'b0;
         pass2_ff      <= 1'b0;
         resume_off_ff <= '0;
         resume_vld_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_ff       <= pend_in;
         pass2_ff      <= pass2_in;
         resume_off_ff <= resume_off_in;
         resume_vld_ff <= resume_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      iss_ff       <= iss_in;
      pend_off_ff  <= pend_off_in;
      run_ff       <= run_in;
      run_start_ff <= run_start_in;
      have_ff      <= have_in;
      pick_ff      <= pick_in;
      at_ff        <= at_in;
      size_ff      <= size_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

>>> verif/fsb_alloc_checker.sv
`timescale 1ns / 1ps

module fsb_alloc_checker
   import fsb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_type               req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_type               rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic                  pready,
   output int                         pending,
   output int                         fail_count
);

   localparam logic [CSR_ADDR_W-1:0] ADDR_STRATEGY = {REG_STRATEGY, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_BASE     = {REG_REGION_BASE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_LENGTH   = {REG_REGION_LENGTH, 2'b00};

   // mirror of the block's map, resume point and registers
   logic [LEN_LIMIT-1:0] used_map;
   logic [9:0]           resume_offset;
   logic                 resume_valid;
   strategy_type         fit_mode;
   logic [15:0]          region_base;
   logic [10:0]          region_length;

   rsp_type              due_results[$];
   int                   slips;

   // first run of size free entries in [from, len)
   function automatic logic first_free_run(input int unsigned from, input int unsigned len,
                                           input int unsigned size, output int unsigned at);
      int unsigned run;
      run = 0;
      at  = 0;
      for (int unsigned k = from; k < len; k++) begin
         if (!used_map[k]) begin
            run++;
            if (run == size) begin
               at = k + 1 - size;
               return 1'b1;
            end
         end else begin
            run = 0;
         end
      end
      return 1'b0;
   endfunction

   // smallest or largest hole of at least size; earliest hole wins a tie
   function automatic logic pick_hole(input int unsigned len, input int unsigned size,
                                      input logic want_big, output int unsigned at);
      int unsigned k, run, pick_len;
      logic        have;
      have     = 1'b0;
      pick_len = 0;
      k        = 0;
      at       = 0;
      while (k < len) begin
         run = 0;
         while (k + run < len && !used_map[k + run])
            run++;
         if (run >= size && (!have || (want_big ? run > pick_len : run < pick_len))) begin
            have     = 1'b1;
            pick_len = run;
            at       = k;
         end
         k += run + 1;
      end
      return have;
   endfunction

   always @(posedge clock) begin
      req_type     beat;
      rsp_type     want;
      int unsigned len, size, at, stop;
      logic        ok;
      if (reset) begin
         used_map      = '0;
         resume_offset = '0;
         resume_valid  = 1'b0;
         fit_mode      = STRAT_FIRST;
         region_base   = '0;
         region_length = REGION_LENGTH_RESET;
         due_results.delete();
         slips         = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               ADDR_STRATEGY: fit_mode      = strategy_type'(pwdata[1:0]);
               ADDR_BASE:     region_base   = pwdata[15:0];
               ADDR_LENGTH:   region_length = pwdata[10:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            beat = req_data;
            len  = (region_length > LEN_LIMIT) ? LEN_LIMIT : region_length;
            size = beat.request_size;
            want = '0;
            at   = 0;
            ok   = 1'b0;
            if (beat.operation == OP_SET) begin
               if (beat.entry_index < len)
                  used_map[beat.entry_index] = beat.entry_used;
            end else begin
               if (size != 0 && size <= len) begin
                  case (fit_mode)
                     STRAT_FIRST: ok = first_free_run(0, len, size, at);
                     STRAT_NEXT: begin
                        ok = first_free_run(resume_valid ? resume_offset : 0, len, size, at);
                        if (!ok)
                           ok = first_free_run(0, len, size, at);
                     end
                     STRAT_BEST:  ok = pick_hole(len, size, 1'b0, at);
                     STRAT_WORST: ok = pick_hole(len, size, 1'b1, at);
                     default: ;
                  endcase
               end
               // next fit: resume after the block, or rewind on a miss
               if (fit_mode == STRAT_NEXT) begin
                  stop          = at + size;
                  resume_valid  = ok;
                  resume_offset = (!ok || stop >= len) ? 10'd0 : stop[9:0];
               end
               if (ok) begin
                  want.found         = 1'b1;
                  want.block_address = 17'(region_base + at);
               end
            end
            due_results.push_back(want);
         end

         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               if (slips < 10)
                  $display("%0t: result beat with nothing outstanding: found=%0b addr=0x%05h",
                           $realtime, rsp_data.found, rsp_data.block_address);
               slips++;
            end else begin
               want = due_results.pop_front();
               if (rsp_data.found !== want.found ||
                   rsp_data.block_address !== want.block_address) begin
                  if (slips < 10)
                     $display("%0t: result mismatch: expected found=%0b addr=0x%05h, got found=%0b addr=0x%05h",
                              $realtime, want.found, want.block_address,
                              rsp_data.found, rsp_data.block_address);
                  slips++;
               end
            end
         end
      end
      pending    <= due_results.size();
      fail_count <= slips;
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import fsb_pkg::*;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int pending;
   int fail_count;
   int idle_pct  = 0;
   int stall_pct = 0;
   int beats_sent, searches_sent, settings_run;

   free_block_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   fsb_alloc_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("free_block_search verification failed");
      $finish;
   end

   function automatic req_type beat_of(input logic op, input int unsigned idx,
                                       input logic used, input int unsigned size);
      req_type b;
      b.operation    = op;
      b.entry_index  = idx[9:0];
      b.entry_used   = used;
      b.request_size = size[10:0];
      return b;
   endfunction

   // valid stays high after a beat only when the next one follows straight on
   task automatic send(input req_type beat);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (beat.operation == OP_SEARCH)
         searches_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   task automatic set_reg(input logic [1:0] reg_index, input logic [31:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      req_type     beat;
      int unsigned eff, density, r, region_len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // whole map, first fit, nothing used yet
      send(beat_of(OP_SEARCH, 0, 1'b0, 1));
      send(beat_of(OP_SEARCH, 10'h3FF, 1'b1, 1024));
      send(beat_of(OP_SEARCH, 0, 1'b0, 0));
      send(beat_of(OP_SET, 0, 1'b1, 0));
      send(beat_of(OP_SET, 10'h3FF, 1'b1, 1024));
      send(beat_of(OP_SEARCH, 0, 1'b0, 1024));
      send(beat_of(OP_SEARCH, 0, 1'b0, 1022));

      // short region at the top of the address range: carry into bit 16
      set_reg(REG_REGION_BASE, 32'hFFFF);
      set_reg(REG_REGION_LENGTH, 32'd8);
      send(beat_of(OP_SET, 8, 1'b1, 0));
      send(beat_of(OP_SEARCH, 0, 1'b0, 9));
      send(beat_of(OP_SEARCH, 0, 1'b0, 7));
      send(beat_of(OP_SET, 4, 1'b1, 0));
      send(beat_of(OP_SET, 6, 1'b1, 0));

      set_reg(REG_STRATEGY, 32'(STRAT_BEST));
      send(beat_of(OP_SEARCH, 0, 1'b0, 1));
      set_reg(REG_STRATEGY, 32'(STRAT_WORST));
      send(beat_of(OP_SEARCH, 0, 1'b0, 3));
      send(beat_of(OP_SEARCH, 0, 1'b0, 4));

      // next fit: resume, wrap to a second pass, then rewind on a miss
      set_reg(REG_STRATEGY, 32'(STRAT_NEXT));
      send(beat_of(OP_SEARCH, 0, 1'b0, 1));
      send(beat_of(OP_SEARCH, 0, 1'b0, 1));
      send(beat_of(OP_SEARCH, 0, 1'b0, 3));
      send(beat_of(OP_SEARCH, 0, 1'b0, 8));
      send(beat_of(OP_SEARCH, 0, 1'b0, 1));

      set_reg(REG_REGION_LENGTH, 32'd0);
      send(beat_of(OP_SEARCH, 0, 1'b0, 1));
      send(beat_of(OP_SET, 0, 1'b0, 0));
      set_reg(REG_REGION_LENGTH, 32'd2047);
      send(beat_of(OP_SEARCH, 0, 1'b0, 1024));
      settings_run = 4;

      for (int chunk = 0; chunk < 13; chunk++) begin
         case (chunk % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         case (chunk)
            5:       region_len = 1024;
            10:      region_len = 2047;
            7:       region_len = 1;
            default: region_len = $urandom_range(2, 48);
         endcase
         eff     = (region_len > LEN_LIMIT) ? LEN_LIMIT : region_len;
         density = $urandom_range(15, 75);
         set_reg(REG_STRATEGY, 32'((chunk + chunk / 4) % 4));
         set_reg(REG_REGION_BASE, (chunk == 1) ? 32'hFFFF :
                                  (chunk == 2) ? 32'h0 : 32'($urandom_range(0, 65535)));
         set_reg(REG_REGION_LENGTH, region_len);
         settings_run++;

         for (int n = 0; n < 43; n++) begin
            // hold off now and then until every result is back
            if ($urandom_range(0, 29) == 0)
               drain();
            beat.operation   = ($urandom_range(0, 99) < 55) ? OP_SET : OP_SEARCH;
            beat.entry_index = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                           : 10'($urandom_range(0, eff - 1));
            beat.entry_used  = ($urandom_range(0, 99) < density);
            r = $urandom_range(0, 19);
            if (r == 0)
               beat.request_size = '0;
            else if (r == 1)
               beat.request_size = 11'($urandom_range(eff, 1024));
            else if (r == 2)
               beat.request_size = 11'($urandom_range(0, 1024));
            else
               beat.request_size = 11'($urandom_range(1, (eff > 8) ? eff / 3 : eff));
            send(beat);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d beats (%0d searches, %0d map writes) over %0d region settings,",
               beats_sent, searches_sent, beats_sent - searches_sent, settings_run);
      $display("all four fit modes, lengths 0 to 2047, bases 0 and 0xFFFF, idle/stall mixes.");
      if (fail_count == 0 && pending == 0) begin
         $display("free_block_search verification clean");
      end else begin
         $display("free_block_search verification failed");
      end
      $finish;
   end

endmodule
